// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the bitmap-to-RGB565 RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is high.
`define BP2R_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define BP2R_NEVER(lbl, clk, rst, cond, msg) \
   `BP2R_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ----- hdl/bp2r_pkg.sv -----
// Package for the bitmap pixel-array to RGB565 converter.
// Holds sizes, command and CSR codes, job and config types, color packing.
// No dependencies.
package bp2r_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W = 11;                    // width/height register size
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PROD_W = ROW_W + DIM_W;
   localparam int PIX_W = 16;
   localparam int IDX_W = 20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   // commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP   = 2'd3;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd320;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd170;

   // 24-bit byte phase
   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   typedef struct packed {
      logic             palette_mode;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic             big_endian_flip;
   } cfg_type;

   // one unit of work for the back end: palette write or pixel
   typedef struct packed {
      logic             is_load;
      logic             use_palette;
      logic [7:0]       addr;       // palette entry (load or lookup)
      logic [23:0]      rgb;        // {red, green, blue}
      logic [ROW_W-1:0] dst_row;
      logic [DIM_W-1:0] width;
      logic [COL_W-1:0] column;
      logic             flip;
      logic             last;
   } job_type;

   function automatic logic [PIX_W-1:0] to_565(input logic [23:0] rgb, input logic flip);
      logic [PIX_W-1:0] w;
      w = {rgb[23:19], rgb[15:10], rgb[7:3]};
      return flip ? {w[7:0], w[15:8]} : w;
   endfunction

endpackage

// ----- hdl/bp2r_req_if.sv -----
// Input channel: one command word per handshake.
// Depends on nothing.
interface bp2r_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic [7:0] palette_index;
   logic [7:0] palette_blue;
   logic [7:0] palette_green;
   logic [7:0] palette_red;

   modport source (output valid, command, data_byte, palette_index,
                   palette_blue, palette_green, palette_red, input ready);
   modport sink   (input valid, command, data_byte, palette_index,
                   palette_blue, palette_green, palette_red, output ready);
endinterface

// ----- hdl/bp2r_rsp_if.sv -----
// Result channel: one RGB565 pixel word per handshake.
// Depends on nothing.
interface bp2r_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rgb565_pixel;
   logic [19:0] pixel_index;
   logic        last_pixel;

   modport source (output valid, rgb565_pixel, pixel_index, last_pixel, input ready);
   modport sink   (input valid, rgb565_pixel, pixel_index, last_pixel, output ready);
endinterface

// ----- hdl/bp2r_front.sv -----
// Front end: accepts command words, tracks byte phase, padding and position.
// Depends on bp2r_pkg and bp2r_req_if; feeds jobs into bp2r_queue.
module bp2r_front (
   input  logic                clock,
   input  logic                reset,
   input  bp2r_pkg::cfg_type   cfg,
   bp2r_req_if.sink            req,
   input  logic                queue_full,
   output logic                push_valid,
   output bp2r_pkg::job_type   push_job
);

   logic [1:0]                 phase_ff, phase_in;
   logic [7:0]                 blue_ff, blue_in;
   logic [7:0]                 green_ff, green_in;
   logic [bp2r_pkg::COL_W-1:0] col_ff, col_in;
   logic [bp2r_pkg::ROW_W-1:0] row_ff, row_in;
   logic [1:0]                 pad_ff, pad_in;
   logic                       done_ff, done_in;

   logic                       accept;
   logic [bp2r_pkg::DIM_W-1:0] w_eff, h_eff, w_last, h_last;
   logic [bp2r_pkg::ROW_W-1:0] row_eff, dst_row;
   logic                       col_end, row_end, fire;
   logic [1:0]                 row_bytes_low, pad_next;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // size clamp: zero acts as one, above max acts as max
      if (cfg.image_width == '0)
         w_eff = bp2r_pkg::DIM_W'(1);
      else if (cfg.image_width > bp2r_pkg::DIM_W'(bp2r_pkg::MAX_WIDTH))
         w_eff = bp2r_pkg::DIM_W'(bp2r_pkg::MAX_WIDTH);
      else
         w_eff = cfg.image_width;
      if (cfg.image_height == '0)
         h_eff = bp2r_pkg::DIM_W'(1);
      else if (cfg.image_height > bp2r_pkg::DIM_W'(bp2r_pkg::MAX_HEIGHT))
         h_eff = bp2r_pkg::DIM_W'(bp2r_pkg::MAX_HEIGHT);
      else
         h_eff = cfg.image_height;
      w_last = w_eff - bp2r_pkg::DIM_W'(1);
      h_last = h_eff - bp2r_pkg::DIM_W'(1);

      row_eff = (bp2r_pkg::DIM_W'(row_ff) > h_last) ? h_last[bp2r_pkg::ROW_W-1:0] : row_ff;
      dst_row = cfg.big_endian_flip ? (h_last[bp2r_pkg::ROW_W-1:0] - row_eff) : row_eff;
      col_end = bp2r_pkg::DIM_W'(col_ff) >= w_last;
      row_end = bp2r_pkg::DIM_W'(row_eff) >= h_last;

      // row byte count mod 4: w or 3w
      row_bytes_low = cfg.palette_mode ? w_eff[1:0] : 2'(w_eff[1:0] + {w_eff[0], 1'b0});
      pad_next      = 2'(~row_bytes_low + 2'd1);
   end

   always_comb begin
      phase_in = phase_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pad_in   = pad_ff;
      done_in  = done_ff;
      fire     = 1'b0;
      push_valid = 1'b0;

      push_job             = '0;
      push_job.addr        = req.data_byte;
      push_job.rgb         = {req.data_byte, green_ff, blue_ff};
      push_job.use_palette = cfg.palette_mode;
      push_job.dst_row     = dst_row;
      push_job.width       = w_eff;
      push_job.column      = col_ff;
      push_job.flip        = cfg.big_endian_flip;
      push_job.last        = col_end && row_end;

      if (accept) begin
         case (req.command)
            bp2r_pkg::CMD_START: begin
               phase_in = bp2r_pkg::PHASE_BLUE;
               col_in   = '0;
               row_in   = '0;
               pad_in   = '0;
               done_in  = 1'b0;
            end
            bp2r_pkg::CMD_LOAD: begin
               push_valid       = 1'b1;
               push_job.is_load = 1'b1;
               push_job.addr    = req.palette_index;
               push_job.rgb     = {req.palette_red, req.palette_green, req.palette_blue};
            end
            bp2r_pkg::CMD_PIXEL: begin
               if (!done_ff) begin
                  if (pad_ff != 2'd0)
                     pad_in = pad_ff - 2'd1;
                  else if (cfg.palette_mode)
                     fire = 1'b1;
                  else begin
                     case (phase_ff)
                        bp2r_pkg::PHASE_BLUE: begin
                           blue_in  = req.data_byte;
                           phase_in = bp2r_pkg::PHASE_GREEN;
                        end
                        bp2r_pkg::PHASE_GREEN: begin
                           green_in = req.data_byte;
                           phase_in = bp2r_pkg::PHASE_RED;
                        end
                        default: fire = 1'b1;
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      if (fire) begin
         push_valid = 1'b1;
         phase_in   = bp2r_pkg::PHASE_BLUE;
         row_in     = row_eff;
         if (col_end) begin
            col_in = '0;
            if (row_end)
               done_in = 1'b1;
            else begin
               pad_in = pad_next;
               row_in = row_eff + bp2r_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + bp2r_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bp2r_pkg::PHASE_BLUE;
         col_ff   <= '0;
         row_ff   <= '0;
         pad_ff   <= '0;
         done_ff  <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pad_ff   <= pad_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

endmodule

// ----- hdl/bp2r_queue.sv -----
// Short job queue between front and back end.
// Depends on bp2r_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bp2r_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bp2r_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output bp2r_pkg::job_type pop_job,
   input  logic              pop_ready
);

   localparam int DEPTH = bp2r_pkg::QUEUE_DEPTH;
   localparam int PW    = bp2r_pkg::QPTR_W;

   bp2r_pkg::job_type entries_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]       count_ff;
   logic              push, pop;

   assign full      = count_ff == (PW+1)'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   `BP2R_ASSERT(a_count_bound, clock, reset, count_ff <= (PW+1)'(DEPTH), "queue overfilled")
   `BP2R_NEVER(a_push_full, clock, reset, push_valid && full, "job pushed into full queue")
   `BP2R_ASSERT(a_ptr_count, clock, reset, count_ff[PW-1:0] == PW'(wr_ptr_ff - rd_ptr_ff), "pointers disagree with count")

endmodule

// ----- hdl/bp2r_back.sv -----
// Back end: palette RAM, index multiply and RGB565 output register.
// Depends on bp2r_pkg, bp2r_rsp_if and assert_macros.svh.
`include "assert_macros.svh"
module bp2r_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  bp2r_pkg::job_type pop_job,
   output logic              pop_ready,
   bp2r_rsp_if.source        rsp
);

   logic [23:0] palette_mem [256];

   // stage 1: lookup and multiply
   logic                        s1_valid_ff;
   logic [23:0]                 pal_rd_ff;
   logic [23:0]                 direct_ff;
   logic                        use_pal_ff;
   logic [bp2r_pkg::PROD_W-1:0] product_ff;
   logic [bp2r_pkg::COL_W-1:0]  column_ff;
   logic                        flip_ff;
   logic                        last_ff;

   // output register
   logic                        rsp_valid_ff;
   logic [bp2r_pkg::PIX_W-1:0]  pixel_ff;
   logic [bp2r_pkg::IDX_W-1:0]  index_ff;
   logic                        rsp_last_ff;

   logic out_load, s1_ready, adv1, s1_fire;

   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign s1_ready  = !s1_valid_ff || out_load;
   assign pop_ready = s1_ready;
   assign adv1      = pop_valid && s1_ready;
   assign s1_fire   = s1_valid_ff && out_load;

   always_ff @(posedge clock) begin
      if (adv1 && pop_job.is_load)
         palette_mem[pop_job.addr] <= pop_job.rgb;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         pal_rd_ff  <= palette_mem[pop_job.addr];
         direct_ff  <= pop_job.rgb;
         use_pal_ff <= pop_job.use_palette;
         product_ff <= bp2r_pkg::PROD_W'(pop_job.dst_row) *
                       bp2r_pkg::PROD_W'(pop_job.width);
         column_ff  <= pop_job.column;
         flip_ff    <= pop_job.flip;
         last_ff    <= pop_job.last;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         pixel_ff    <= bp2r_pkg::to_565(use_pal_ff ? pal_rd_ff : direct_ff, flip_ff);
         index_ff    <= bp2r_pkg::IDX_W'(product_ff + bp2r_pkg::PROD_W'(column_ff));
         rsp_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1)
            s1_valid_ff <= !pop_job.is_load;
         else if (out_load)
            s1_valid_ff <= 1'b0;
         if (out_load)
            rsp_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.rgb565_pixel = pixel_ff;
   assign rsp.pixel_index  = index_ff;
   assign rsp.last_pixel   = rsp_last_ff;

   `BP2R_ASSERT(a_s1_hold, clock, reset, s1_valid_ff && !out_load |=> s1_valid_ff, "stage 1 pixel dropped under stall")
   `BP2R_ASSERT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp.ready |=> rsp_valid_ff, "word dropped under stall")
   `BP2R_ASSERT(a_rsp_stable, clock, reset, rsp_valid_ff && !rsp.ready |=> $stable(pixel_ff) && $stable(index_ff) && $stable(rsp_last_ff), "word changed under stall")

endmodule

// ----- hdl/bmp_pixels_to_rgb565_core.sv -----
// Top level of the bitmap pixel-array to RGB565 converter.
// Depends on bp2r_pkg, bp2r_req_if, bp2r_rsp_if, bp2r_front, bp2r_queue, bp2r_back.
//
//   port       dir   handshake          carries
//   req_chan   in    valid/ready        command, data byte, palette entry
//   rsp_chan   out   valid/ready        rgb565 word, pixel index, last flag
//   csr_*      in    write enable only  register index, 11-bit data
//
// Flow: one input word per clock while the job queue is not full; a pixel's
//   word reaches rsp_chan through the queue entry, stage 1 with the palette
//   RAM read and row*width multiply, and the output register.
// Reset: synchronous, active high; counters idle until a start command.
//   The palette RAM is not cleared; entries hold garbage until loaded.
// Stalls: a four-entry job queue sits between front and back, so req_chan
//   keeps taking words while rsp_chan is held; it drops ready only when full.
module bmp_pixels_to_rgb565_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bp2r_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bp2r_pkg::CSR_DATA_W-1:0] csr_wdata,
   bp2r_req_if.sink                       req_chan,
   bp2r_rsp_if.source                     rsp_chan
);

   bp2r_pkg::cfg_type cfg_ff;
   bp2r_pkg::job_type push_job, pop_job;
   logic              push_valid, queue_full, pop_valid, pop_ready;

   // config registers, read live by the front end
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette_mode    <= 1'b0;
         cfg_ff.image_width     <= bp2r_pkg::RESET_WIDTH;
         cfg_ff.image_height    <= bp2r_pkg::RESET_HEIGHT;
         cfg_ff.big_endian_flip <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            bp2r_pkg::CSR_MODE:   cfg_ff.palette_mode    <= csr_wdata[0];
            bp2r_pkg::CSR_WIDTH:  cfg_ff.image_width     <= csr_wdata;
            bp2r_pkg::CSR_HEIGHT: cfg_ff.image_height    <= csr_wdata;
            bp2r_pkg::CSR_FLIP:   cfg_ff.big_endian_flip <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // byte phase, padding skip, row/column tracking
   bp2r_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // decouples byte intake from result backpressure
   bp2r_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // palette writes and lookups stay in job order, so loads are seen in time
   bp2r_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule
